@@ design/adjacent_box_grouping_defines.svh @@
// Assertion macros for the box grouping block.
`ifndef ADJACENT_BOX_GROUPING_DEFINES_SVH
`define ADJACENT_BOX_GROUPING_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ABG_ASSERT_SAME(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("abg check failed");
`define ABG_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("abg check failed");
`else
`define ABG_ASSERT_SAME(lbl, a, c)
`define ABG_ASSERT_NEXT(lbl, a, c)
`endif
`endif

@@ design/abg_pkg.sv @@
// Shared types and constants for the box grouping block.
package abg_pkg;
	localparam int COORD_W       = 16;
	localparam int MAX_BOXES_DEF = 64;
	localparam int BOX_NUM_W     = 6;
	localparam int GRP_NUM_W     = 6;
	localparam int TOTAL_W       = 7;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_START, ST_SCAN_RD, ST_SCAN_EV, ST_MERGE_RD, ST_MERGE_EV,
		ST_REMAP_RD, ST_REMAP_MAP, ST_REMAP_WR, ST_COMMIT, ST_DONE, ST_OUT_RD, ST_OUT_SHOW
	} state_t;

	typedef struct packed {
		logic load;
		logic cnt_clr;
		logic cnt_inc;
		logic set_ovf;
		logic scan_ev;
		logic merge_ev;
		logic remap_wr;
		logic commit;
		logic out_load;
		logic list_clr;
		logic clr_wr;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic final_box;
		logic any;
		logic scan_last;
		logic merge_last;
		logic clr_last;
		logic out_free;
	} sts_t;
endpackage

@@ design/adjacent_box_grouping.sv @@
// Top level of the adjacent box grouping block.
// Usage:
//  s_axis carries one inclusive 3-D box per transaction; s_axis_tlast marks the
//  last box of a list. m_axis returns, after the last box, one transaction per
//  stored box in arrival order: its box number, final group number, the group
//  total, an overflow flag (tuser) and tlast on the final stored box.
//  Each new box is grown by one cell and checked against all n stored boxes,
//  then the g groups are renumbered and, if the box touched any group, the n
//  labels are rewritten. A box that touches nothing skips the relabel pass.
//  These passes run through single-port style memories, one entry per step.
//  A box arriving with the store full is dropped and only sets the overflow
//  flag.
//  Output streaming reads and then loads one result at a time; a stalled
//  receiver holds the result register and the walk waits. The next box is
//  taken once the last result is loaded, while it may still be waiting on
//  m_axis. After reset the merge flag table is cleared one entry per step
//  before s_axis_tready rises; the stored list is empty after reset.
module adjacent_box_grouping
	import abg_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// low_x, low_y, low_z, high_x, high_y, high_z
	input  logic [6*COORD_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// box_number, group_number, group_total, zero pad
	output logic [23:0]          m_axis_tdata,
	// overflowed
	output logic                 m_axis_tuser,
	output logic                 m_axis_tlast
);
`include "adjacent_box_grouping_defines.svh"

	cmd_t cmd;
	sts_t sts;
	logic [BOX_NUM_W-1:0] box_number;
	logic [GRP_NUM_W-1:0] group_number;
	logic [TOTAL_W-1:0]   group_total;

	abg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	abg_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_box           (s_axis_tdata),
		.in_final         (s_axis_tlast),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_box_number   (box_number),
		.out_group_number (group_number),
		.out_group_total  (group_total),
		.out_overflowed   (m_axis_tuser),
		.out_final        (m_axis_tlast)
	);

	assign m_axis_tdata = {5'b0, group_total, group_number, box_number};

	// one box in flight at a time
	`ABG_ASSERT_NEXT(a_one_box, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// a pending result is never overwritten
	`ABG_ASSERT_SAME(a_no_overwrite, cmd.out_load, !m_axis_tvalid || m_axis_tready)
	// nothing is stored past capacity
	`ABG_ASSERT_SAME(a_no_overfill, cmd.commit, !sts.full)
endmodule

@@ design/abg_ctrl.sv @@
// Controller state machine for the box grouping block.
module abg_ctrl
	import abg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = ST_START;
				end
			end
			ST_START: begin
				priority if (sts.full) begin
					cmd.set_ovf = 1'b1;
					state_d     = ST_DONE;
				end else if (sts.empty) begin
					state_d = ST_COMMIT;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_EV;
			ST_SCAN_EV: begin
				cmd.scan_ev = 1'b1;
				if (sts.scan_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_MERGE_RD;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_MERGE_RD: state_d = ST_MERGE_EV;
			ST_MERGE_EV: begin
				cmd.merge_ev = 1'b1;
				if (sts.merge_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = sts.any ? ST_REMAP_RD : ST_COMMIT;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = ST_MERGE_RD;
				end
			end
			ST_REMAP_RD:  state_d = ST_REMAP_MAP;
			ST_REMAP_MAP: state_d = ST_REMAP_WR;
			ST_REMAP_WR: begin
				cmd.remap_wr = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_COMMIT;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = ST_REMAP_RD;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				cmd.cnt_clr = 1'b1;
				state_d     = sts.final_box ? ST_OUT_RD : ST_IDLE;
			end
			ST_OUT_RD: state_d = ST_OUT_SHOW;
			ST_OUT_SHOW: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.scan_last) begin
						cmd.list_clr = 1'b1;
						cmd.cnt_clr  = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
						state_d     = ST_OUT_RD;
					end
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end
endmodule

@@ design/abg_dp.sv @@
// Datapath: box store, group labels, merge tables and result register.
module abg_dp
	import abg_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [6*COORD_W-1:0] in_box,
	input  logic                 in_final,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BOX_NUM_W-1:0] out_box_number,
	output logic [GRP_NUM_W-1:0] out_group_number,
	output logic [TOTAL_W-1:0]   out_group_total,
	output logic                 out_overflowed,
	output logic                 out_final
);
	localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int BW = 6 * COORD_W;

	logic [BW-1:0] box_mem [MAX_BOXES];
	logic [IW-1:0] grp_mem [MAX_BOXES];
	logic          hit_mem [MAX_BOXES];
	logic [IW-1:0] nix_mem [MAX_BOXES];

	logic [BW-1:0] box_rd_q;
	logic [IW-1:0] grp_rd_q, nix_rd_q;
	logic          hit_rd_q;

	logic [BW-1:0] box_q;
	logic          final_q;
	logic [CW-1:0] cnt_q, n_q, g_q, shift_q;
	logic [IW-1:0] keep_q;
	logic          any_q, ovf_q;

	logic [IW-1:0] idx;
	logic [CW-1:0] cnt_nx;
	logic          touch;
	logic          hit_we, hit_wd;
	logic [IW-1:0] hit_wa;
	logic          grp_we;
	logic [IW-1:0] grp_wa, grp_wd;
	logic [IW-1:0] nix_wd;
	logic [31:0]   cnt_ext, g_ext, grp_ext;

	assign idx    = cnt_q[IW-1:0];
	assign cnt_nx = CW'(cnt_q + 1'b1);

	// grown new box against stored box, all three axes
	always_comb begin
		logic signed [COORD_W:0] glo, ghi, slo, shi;
		touch = 1'b1;
		for (int d = 0; d < 3; d++) begin
			glo = {box_q[d*COORD_W+COORD_W-1], box_q[d*COORD_W +: COORD_W]} - 1'b1;
			ghi = {box_q[(d+3)*COORD_W+COORD_W-1], box_q[(d+3)*COORD_W +: COORD_W]} + 1'b1;
			slo = {box_rd_q[d*COORD_W+COORD_W-1], box_rd_q[d*COORD_W +: COORD_W]};
			shi = {box_rd_q[(d+3)*COORD_W+COORD_W-1], box_rd_q[(d+3)*COORD_W +: COORD_W]};
			if (glo > shi || slo > ghi || glo > ghi || slo > shi) touch = 1'b0;
		end
	end

	// merge table entry for group idx
	always_comb begin
		if (hit_rd_q && any_q) nix_wd = keep_q;
		else nix_wd = IW'(cnt_q - shift_q);
	end

	always_comb begin
		hit_we = 1'b0;
		hit_wa = idx;
		hit_wd = 1'b0;
		if (cmd.scan_ev) begin
			hit_we = touch;
			hit_wa = grp_rd_q;
			hit_wd = 1'b1;
		end else if (cmd.merge_ev || cmd.clr_wr) begin
			hit_we = 1'b1;
		end
		grp_we = cmd.remap_wr | cmd.commit;
		grp_wa = cmd.commit ? n_q[IW-1:0] : idx;
		grp_wd = cmd.commit ? (any_q ? keep_q : g_q[IW-1:0]) : nix_rd_q;
	end

	always_ff @(posedge clk) begin
		box_rd_q <= box_mem[idx];
		grp_rd_q <= grp_mem[idx];
		hit_rd_q <= hit_mem[idx];
		nix_rd_q <= nix_mem[grp_rd_q];
		if (cmd.commit) box_mem[n_q[IW-1:0]] <= box_q;
		if (grp_we) grp_mem[grp_wa] <= grp_wd;
		if (hit_we) hit_mem[hit_wa] <= hit_wd;
		if (cmd.merge_ev) nix_mem[idx] <= nix_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			box_q   <= in_box;
			final_q <= in_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			n_q     <= '0;
			g_q     <= '0;
			shift_q <= '0;
			keep_q  <= '0;
			any_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_nx;
			if (cmd.load) begin
				shift_q <= '0;
				any_q   <= 1'b0;
				keep_q  <= '0;
			end
			if (cmd.merge_ev && hit_rd_q) begin
				if (any_q) begin
					shift_q <= CW'(shift_q + 1'b1);
				end else begin
					any_q  <= 1'b1;
					keep_q <= idx;
				end
			end
			if (cmd.set_ovf) ovf_q <= 1'b1;
			if (cmd.commit) begin
				n_q <= CW'(n_q + 1'b1);
				g_q <= any_q ? CW'(g_q - shift_q) : CW'(g_q + 1'b1);
			end
			if (cmd.list_clr) begin
				n_q   <= '0;
				g_q   <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// result register
	assign cnt_ext = 32'(cnt_q);
	assign g_ext   = 32'(g_q);
	assign grp_ext = 32'(grp_rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_box_number   <= cnt_ext[BOX_NUM_W-1:0];
			out_group_number <= grp_ext[GRP_NUM_W-1:0];
			out_group_total  <= g_ext[TOTAL_W-1:0];
			out_overflowed   <= ovf_q;
			out_final        <= (cnt_nx == n_q);
		end
	end

	assign sts.full       = (n_q >= CW'(MAX_BOXES));
	assign sts.empty      = (n_q == '0);
	assign sts.final_box  = final_q;
	assign sts.any        = any_q | hit_rd_q;
	assign sts.scan_last  = (cnt_nx == n_q);
	assign sts.merge_last = (cnt_nx == g_q);
	assign sts.clr_last   = (cnt_nx == CW'(MAX_BOXES));
	assign sts.out_free   = ~out_valid | out_ready;
endmodule

@@ tb/tb_adjacent_box_grouping.sv @@
// Self-checking testbench for the adjacent box grouping block.
module tb_adjacent_box_grouping;
	import abg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBOX = MAX_BOXES_DEF;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [6*COORD_W-1:0] s_axis_tdata; // low_x, low_y, low_z, high_x, high_y, high_z
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;          // box_number, group_number, group_total, zero pad
	logic m_axis_tuser;                 // overflowed
	logic m_axis_tlast;

	adjacent_box_grouping dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	typedef struct packed {
		logic signed [COORD_W-1:0] hz, hy, hx, lz, ly, lx;
	} box_t;

	typedef struct {
		logic [BOX_NUM_W-1:0] box_num;
		logic [GRP_NUM_W-1:0] grp_num;
		logic [TOTAL_W-1:0]   total;
		logic                 ovf;
		logic                 last;
	} label_t;

	// predictor state: stored boxes and their group labels
	box_t    grid_box [NBOX];
	int      grid_grp [NBOX];
	int      n_stored, n_groups;
	bit      dropped;
	label_t  label_q[$];

	int errors = 0;
	int n_results = 0;
	int n_lists = 0;
	bit sender_gaps = 1, receiver_gaps = 1;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("TIMEOUT at %0t", $time);
		$display("adjacent_box_grouping verification failed");
		$finish;
	end

	// grown new box against stored box k, corner contact included
	function automatic bit box_touches(box_t b, int k);
		int glo[3], ghi[3], slo[3], shi[3];
		int d;
		glo = '{int'(b.lx) - 1, int'(b.ly) - 1, int'(b.lz) - 1};
		ghi = '{int'(b.hx) + 1, int'(b.hy) + 1, int'(b.hz) + 1};
		slo = '{int'(grid_box[k].lx), int'(grid_box[k].ly), int'(grid_box[k].lz)};
		shi = '{int'(grid_box[k].hx), int'(grid_box[k].hy), int'(grid_box[k].hz)};
		for (d = 0; d < 3; d++) begin
			if ((glo[d] > slo[d] ? glo[d] : slo[d]) > (ghi[d] < shi[d] ? ghi[d] : shi[d]))
				return 0;
		end
		return 1;
	endfunction

	// fold one box into the groups; on the final box queue the labels
	task automatic group_box(box_t b, bit fin);
		bit hit[NBOX];
		int remap[NBOX];
		int keep, shift, k;
		bit any;
		label_t lbl;
		any = 0; keep = 0; shift = 0;
		if (n_stored >= NBOX) begin
			dropped = 1;
		end else begin
			for (k = 0; k < NBOX; k++) hit[k] = 0;
			for (k = 0; k < n_stored; k++)
				if (box_touches(b, k)) hit[grid_grp[k]] = 1;
			for (k = 0; k < n_groups; k++) begin
				if (hit[k] && !any) begin
					keep = k; any = 1;
				end
				if (hit[k] && k != keep) begin
					remap[k] = keep; shift++;
				end else begin
					remap[k] = k - shift;
				end
			end
			if (!any) begin
				grid_grp[n_stored] = n_groups;
				n_groups++;
			end else begin
				for (k = 0; k < n_stored; k++) grid_grp[k] = remap[grid_grp[k]];
				grid_grp[n_stored] = keep;
				n_groups -= shift;
			end
			grid_box[n_stored] = b;
			n_stored++;
		end
		if (fin) begin
			for (k = 0; k < n_stored; k++) begin
				lbl.box_num = BOX_NUM_W'(k);
				lbl.grp_num = GRP_NUM_W'(grid_grp[k]);
				lbl.total   = TOTAL_W'(n_groups);
				lbl.ovf     = dropped;
				lbl.last    = (k + 1 == n_stored);
				label_q.insert(label_q.size(), lbl);
			end
			n_stored = 0; n_groups = 0; dropped = 0; n_lists++;
		end
	endtask

	function automatic bit gap_now(bit enabled);
		return enabled && $urandom_range(99) < 23;
	endfunction

	// one transaction on s_axis, with random idle before it
	task automatic send_box(box_t b, bit fin);
		while (gap_now(sender_gaps)) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		group_box(b, fin);
		@(negedge clk);
	endtask

	function automatic box_t make_box(int x, int y, int z, int sx, int sy, int sz);
		box_t b;
		b.lx = COORD_W'(x); b.ly = COORD_W'(y); b.lz = COORD_W'(z);
		b.hx = COORD_W'(x + sx); b.hy = COORD_W'(y + sy); b.hz = COORD_W'(z + sz);
		return b;
	endfunction

	// receiver: random stalls, compare against the oldest label
	always @(negedge clk) m_axis_tready <= !gap_now(receiver_gaps);

	always @(posedge clk) begin
		label_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (label_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				want = label_q.pop_front();
				if (m_axis_tdata[5:0] !== want.box_num || m_axis_tdata[11:6] !== want.grp_num ||
				    m_axis_tdata[18:12] !== want.total || m_axis_tdata[23:19] !== 5'd0 ||
				    m_axis_tuser !== want.ovf || m_axis_tlast !== want.last) begin
					$display("%0t: mismatch expected box %0d grp %0d tot %0d ovf %b last %b",
						$time, want.box_num, want.grp_num, want.total, want.ovf, want.last);
					$display("%0t:          actual   box %0d grp %0d tot %0d ovf %b last %b",
						$time, m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tdata[18:12],
						m_axis_tuser, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// directed rows: box, final flag
	typedef struct {
		box_t b;
		bit   fin;
	} row_t;

	row_t plan[$];
	box_t rb;
	int i, j, len, cx, cy, cz, wait_cyc;

	task automatic add_row(box_t b, bit fin);
		row_t r;
		r.b   = b;
		r.fin = fin;
		plan.insert(plan.size(), r);
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		m_axis_tready = 0;
		n_stored = 0; n_groups = 0; dropped = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// single box; extremes; corner touch; gap of one cell; inverted box; merge of three
		add_row(make_box(0, 0, 0, 0, 0, 0), 1);
		add_row('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000}, 0);
		add_row('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0);
		add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1);
		add_row(make_box(0, 0, 0, 1, 1, 1), 0);
		add_row(make_box(2, 2, 2, 0, 0, 0), 0);   // corner contact
		add_row(make_box(4, 2, 2, 0, 0, 0), 0);   // one-cell gap, new group
		add_row(make_box(10, 0, 0, 0, 0, 0), 0);
		add_row(make_box(5, 5, 5, -2, 0, 0), 0);  // inverted, own group
		add_row(make_box(5, 0, 0, 4, 2, 2), 0);   // bridges groups
		add_row(make_box(20, 20, 20, 0, 0, 0), 1);
		add_row(make_box(-5, -5, -5, 0, 0, 0), 0);
		add_row(make_box(-3, -5, -5, 0, 0, 0), 0);
		add_row(make_box(-4, -5, -5, 0, 0, 0), 1);
		foreach (plan[i]) send_box(plan[i].b, plan[i].fin);

		// overflow: a full store plus dropped boxes, and a dropped final box
		for (i = 0; i < NBOX + 2; i++)
			send_box(make_box(i * 3, 0, 0, 0, 0, 0), i == NBOX + 1);
		s_axis_tvalid <= 0;

		// hold off until every label has come back
		while (label_q.size() != 0) @(negedge clk);

		// random lists, mostly clustered boxes so merges happen
		i = 0;
		while (i < 140) begin
			if (i > 80 && i < 130) begin
				sender_gaps = 0; receiver_gaps = 0;
			end else begin
				sender_gaps = 1; receiver_gaps = 1;
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 12);
			if (len > 140 - i) len = 140 - i;
			for (j = 0; j < len; j++) begin
				if ($urandom_range(9) == 0) begin
					rb = {$urandom, $urandom, $urandom};
				end else begin
					cx = $urandom_range(12); cy = $urandom_range(12); cz = $urandom_range(12);
					if ($urandom_range(1)) begin
						cx = -cx; cy = cy - 20000;
					end
					rb = make_box(cx, cy, cz, $urandom_range(3), $urandom_range(3),
						$urandom_range(3));
					if ($urandom_range(19) == 0) rb.hz = rb.lz - 16'sd1;
				end
				send_box(rb, j == len - 1);
				i++;
			end
		end
		s_axis_tvalid <= 0;

		wait_cyc = 0;
		while (label_q.size() != 0 && wait_cyc < 200000) begin
			@(negedge clk); wait_cyc++;
		end
		repeat (600) @(negedge clk);
		$display("Covered %0d box lists, %0d labels checked, incl. overflow and inverted boxes.",
			n_lists, n_results);
		if (errors == 0 && label_q.size() == 0)
			$display("adjacent_box_grouping verification clean");
		else
			$display("adjacent_box_grouping verification failed");
		$finish;
	end
endmodule
